### rtl/core/tcfx_pkg.sv
// ---------------------------------------------------------------------------
// tcfx_pkg
// Shared types, constants, the sine table and period slide helpers of the channel effect engine.
// ---------------------------------------------------------------------------
package tcfx_pkg;

    localparam int CHANNELS = 8;
    localparam int CH_W = 3;
    localparam int PER_W = 20;
    localparam int OFS_W = 13;
    localparam logic [PER_W-1:0] PERIOD_MAX = 20'hFFFFF;
    localparam logic [PER_W-1:0] PERIOD_FLOOR = 20'd10;
    localparam logic [7:0] NO_EFFECT = 8'hFF;
    localparam logic [7:0] NO_TRIGGER = 8'hFE;
    localparam logic [7:0] FX_SLIDE_DOWN = 8'd0;
    localparam logic [7:0] FX_SLIDE_UP = 8'd1;
    localparam logic [7:0] FX_GLIDE = 8'd2;
    localparam logic [7:0] FX_FINETUNE = 8'd3;
    localparam logic [7:0] FX_VIBRATO = 8'd4;
    localparam logic [7:0] FX_SPEED = 8'd5;
    localparam logic [7:0] FX_PAN = 8'd6;
    localparam logic [7:0] FX_RETRIG = 8'd7;
    localparam logic [1:0] GM_IDLE = 2'd0;
    localparam logic [1:0] GM_CAPTURED = 2'd1;
    localparam logic [1:0] GM_GLIDING = 2'd2;
    localparam int QDEPTH = 2;

    typedef struct packed {
        logic             action;
        logic [CH_W-1:0]  channel;
        logic             in_range;
        logic [7:0]       effect_code;
        logic [7:0]       effect_param;
        logic [7:0]       note_code;
        logic [15:0]      note_period;
        logic [7:0]       row_volume;
    } item_t;

    typedef struct packed {
        logic [CH_W-1:0]  out_channel;
        logic [PER_W-1:0] period;
        logic [OFS_W-1:0] period_offset;
        logic             restart_sample;
        logic [7:0]       volume;
        logic [7:0]       pan;
        logic [7:0]       finetune;
        logic             speed_valid;
        logic [7:0]       speed;
    } result_t;

    typedef struct packed {
        logic [7:0]       effect;
        logic [7:0]       param;
        logic [PER_W-1:0] period;
        logic [OFS_W-1:0] offset;
        logic [7:0]       glide_speed;
        logic [PER_W-1:0] glide_target;
        logic [1:0]       glide_mode;
        logic [7:0]       wobble_depth;
        logic [5:0]       wobble_pos;
        logic [7:0]       retrig_left;
        logic [7:0]       volume;
        logic [7:0]       pan;
        logic [7:0]       finetune;
    } chan_t;

    function automatic logic signed [11:0] sine_at(input logic [5:0] idx);
        logic [9:0] q [0:16];
        logic [4:0] k;
        logic [9:0] m;
        q = '{10'd0, 10'd100, 10'd200, 10'd297, 10'd392, 10'd483, 10'd569,
              10'd650, 10'd724, 10'd792, 10'd851, 10'd903, 10'd946, 10'd980,
              10'd1004, 10'd1019, 10'd0};
        k = idx[4] ? (5'd16 - {1'b0, idx[3:0]}) : {1'b0, idx[3:0]};
        m = q[k];
        if (idx[4] && idx[3:0] == 4'd0) begin
            sine_at = idx[5] ? -12'sd1024 : 12'sd1024;
        end else begin
            sine_at = idx[5] ? -$signed({2'b00, m}) : $signed({2'b00, m});
        end
    endfunction

    function automatic logic [PER_W-1:0] slide_up(input logic [PER_W-1:0] p,
                                                  input logic [11:0] amt);
        logic [PER_W:0] s;
        s = {1'b0, p} + {9'd0, amt};
        if (s[PER_W]) slide_up = PERIOD_MAX;
        else if (s[PER_W-1:0] < PERIOD_FLOOR) slide_up = PERIOD_FLOOR;
        else slide_up = s[PER_W-1:0];
    endfunction

    function automatic logic [PER_W-1:0] slide_down(input logic [PER_W-1:0] p,
                                                    input logic [11:0] amt);
        logic [PER_W:0] lim;
        lim = {9'd0, amt} + {1'b0, PERIOD_FLOOR};
        if ({1'b0, p} < lim) slide_down = PERIOD_FLOOR;
        else slide_down = p - {8'd0, amt};
    endfunction

endpackage

### rtl/core/tcfx_front.sv
// ---------------------------------------------------------------------------
// tcfx_front
// Accepts input transactions, classifies them and queues them for the back.
// ---------------------------------------------------------------------------
module tcfx_front import tcfx_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [50:0] s_tdata,
    input  logic        s_tuser,
    output logic        q_valid,
    input  logic        q_ready,
    output item_t       q_item
);
    item_t      mem_reg [QDEPTH];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    item_t      in_item;
    logic       push, pop;

    always_comb begin
        in_item.action = s_tuser;
        in_item.channel = s_tdata[2:0];
        in_item.in_range = ({29'd0, s_tdata[2:0]} < 32'(CHANNELS));
        in_item.effect_code = s_tdata[10:3];
        in_item.effect_param = s_tdata[18:11];
        in_item.note_code = s_tdata[26:19];
        in_item.note_period = s_tdata[42:27];
        in_item.row_volume = s_tdata[50:43];
    end

    assign s_tready = (cnt_reg != 2'(QDEPTH));
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item = mem_reg[rp_reg];
    assign push = s_tvalid && s_tready;
    assign pop = q_valid && q_ready;

    always_comb begin
        wp_next = push ? ~wp_reg : wp_reg;
        rp_next = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (push) mem_reg[wp_reg] <= in_item;
    end

    a_cnt_max: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'(QDEPTH)) else $error("queue count overflow");
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'(QDEPTH)) |-> !s_tready) else $error("accept when full");
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> !q_valid) else $error("valid when empty");
endmodule

### rtl/core/tcfx_back.sv
// ---------------------------------------------------------------------------
// tcfx_back
// Per-channel state and effect execution, one item per cycle while the
// result channel keeps up, with an output register that decouples it.
// ---------------------------------------------------------------------------
module tcfx_back import tcfx_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_valid,
    output logic    q_ready,
    input  item_t   q_item,
    output logic    m_tvalid,
    input  logic    m_tready,
    output result_t m_res
);
    chan_t   st_reg [CHANNELS];
    chan_t   cur, nxt;
    result_t res_reg, res_next;
    logic    ovalid_reg, ovalid_next;
    logic    restart, spd_v;
    logic [7:0] spd, eff, trig, note, par;
    logic [PER_W-1:0] scaled, pg;
    logic [PER_W+1:0] sum;
    logic signed [20:0] prod;
    logic [11:0] amt;
    logic fire;

    assign q_ready = !ovalid_reg || m_tready;
    assign fire = q_valid && q_ready;
    assign cur = st_reg[q_item.channel];

    always_comb begin
        nxt = cur;
        restart = 1'b0;
        spd_v = 1'b0;
        spd = 8'd0;
        eff = q_item.effect_code;
        par = q_item.effect_param;
        note = q_item.note_code;
        trig = note;
        scaled = {q_item.note_period, 4'd0};
        sum = '0;
        prod = '0;
        amt = '0;
        pg = '0;
        if (!q_item.action) begin
            nxt.param = par;
            nxt.effect = eff;
            if (eff == NO_EFFECT) begin
                nxt.offset = '0;
            end else if (eff == FX_SLIDE_DOWN || eff == FX_SLIDE_UP) begin
                sum = {2'b00, cur.period} + {{9{cur.offset[OFS_W-1]}}, cur.offset};
                if (sum[PER_W+1]) nxt.period = '0;
                else if (sum[PER_W]) nxt.period = PERIOD_MAX;
                else nxt.period = sum[PER_W-1:0];
                nxt.offset = '0;
                nxt.wobble_pos = '0;
            end else if (eff == FX_GLIDE) begin
                nxt.wobble_pos = '0;
            end
            if (eff == FX_SPEED && par != 8'd0) begin
                spd_v = 1'b1;
                spd = par;
            end
            if (eff == FX_GLIDE && note != NO_EFFECT && note != NO_TRIGGER) begin
                nxt.offset = '0;
                if (note < 8'd64) begin
                    trig = NO_TRIGGER;
                    nxt.glide_mode = GM_CAPTURED;
                end else begin
                    nxt.glide_mode = GM_IDLE;
                end
            end
            if (trig != NO_EFFECT && trig != NO_TRIGGER) begin
                nxt.period = scaled;
                nxt.wobble_pos = '0;
                nxt.offset = '0;
                restart = 1'b1;
            end
            if (note != NO_EFFECT) nxt.volume = q_item.row_volume;
            case (eff)
                FX_GLIDE: begin
                    if (par != 8'd0) nxt.glide_speed = par;
                    if (nxt.glide_mode == GM_CAPTURED) begin
                        nxt.glide_target = scaled;
                        nxt.glide_mode = GM_GLIDING;
                    end
                    if (nxt.glide_target != nxt.period) begin
                        nxt.wobble_pos = '0;
                        nxt.offset = '0;
                        nxt.glide_mode = GM_GLIDING;
                    end
                end
                FX_FINETUNE: nxt.finetune = par;
                FX_VIBRATO: nxt.wobble_depth = {par[3:0], 4'd1};
                FX_PAN: nxt.pan = 8'(par * 8'd28);
                FX_RETRIG: if (par != 8'd0) nxt.retrig_left = par;
                default: ;
            endcase
        end else begin
            eff = cur.effect;
            if (eff == NO_EFFECT && cur.glide_mode == GM_GLIDING) eff = FX_GLIDE;
            case (eff)
                FX_SLIDE_DOWN: nxt.period = slide_down(cur.period, {cur.param, 4'd0});
                FX_SLIDE_UP: nxt.period = slide_up(cur.period, {cur.param, 4'd0});
                FX_GLIDE: begin
                    amt = {cur.glide_speed, 4'd0};
                    if (cur.glide_target == cur.period || cur.glide_mode != GM_GLIDING) begin
                        nxt.glide_mode = GM_IDLE;
                    end else if (cur.glide_target > cur.period) begin
                        pg = slide_up(cur.period, amt);
                        nxt.period = (pg > cur.glide_target) ? cur.glide_target : pg;
                    end else begin
                        pg = slide_down(cur.period, amt);
                        nxt.period = (pg < cur.glide_target) ? cur.glide_target : pg;
                    end
                end
                FX_VIBRATO: begin
                    prod = 21'(sine_at(cur.wobble_pos)) *
                           $signed({13'd0, cur.wobble_depth});
                    if (prod < 0) prod = prod + 21'sd63;
                    nxt.offset = OFS_W'(prod >>> 6);
                    nxt.wobble_pos = cur.wobble_pos + 6'd1;
                end
                FX_RETRIG: begin
                    if (cur.param != 8'd0) begin
                        nxt.retrig_left = cur.retrig_left - 8'd1;
                        if (nxt.retrig_left == 8'd0) begin
                            nxt.retrig_left = cur.param;
                            restart = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
        res_next = '0;
        res_next.out_channel = q_item.channel;
        if (q_item.in_range) begin
            res_next.period = nxt.period;
            res_next.period_offset = nxt.offset;
            res_next.restart_sample = restart;
            res_next.volume = nxt.volume;
            res_next.pan = nxt.pan;
            res_next.finetune = nxt.finetune;
            res_next.speed_valid = spd_v;
            res_next.speed = spd;
        end
        ovalid_next = fire ? 1'b1 : (m_tready ? 1'b0 : ovalid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                st_reg[i] <= '0;
                st_reg[i].effect <= NO_EFFECT;
            end
        end else begin
            ovalid_reg <= ovalid_next;
            if (fire && q_item.in_range) st_reg[q_item.channel] <= nxt;
        end
        if (fire) res_reg <= res_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_res = res_reg;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(res_reg)))
        else $error("result lost under stall");
    a_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_tvalid) else $error("result missing");
    a_speed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_res.speed_valid) |-> (m_res.speed == 8'd0))
        else $error("speed without valid");
endmodule

### rtl/core/tracker_channel_effect_engine.sv
// ---------------------------------------------------------------------------
// tracker_channel_effect_engine
// Per-channel effect engine: row events and ticks in, channel state out.
// ---------------------------------------------------------------------------
// Channel  Dir  Data
// s_       in   tdata: channel, effect_code, effect_param, note_code,
//                      note_period, row_volume; tuser: action
// m_       out  tdata: out_channel, period, period_offset, restart_sample,
//                      volume, pan, finetune, speed_valid, speed
//
// One transaction per cycle is sustained while m_tready stays high; each
// accepted item passes through the two-entry queue and then the output register.
// The channel state update is a read-modify-write, written back in the same cycle.
// Reset restores all channel state at once; no clearing pass is needed.
// A stalled result channel fills the queue, then deasserts s_tready.
// ---------------------------------------------------------------------------
module tracker_channel_effect_engine import tcfx_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // channel, effect_code, effect_param, note_code, note_period, row_volume
    input  logic [55:0] s_tdata,
    // action
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_channel, period, period_offset, restart_sample, volume, pan,
    // finetune, speed_valid, speed
    output logic [71:0] m_tdata
);
    logic    q_valid, q_ready;
    item_t   q_item;
    result_t r;

    tcfx_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata[50:0]), .s_tuser(s_tuser), .q_valid(q_valid),
        .q_ready(q_ready), .q_item(q_item)
    );

    tcfx_back u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_ready(q_ready),
        .q_item(q_item), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_res(r)
    );

    assign m_tdata = {2'b00, r.speed, r.speed_valid, r.finetune, r.pan, r.volume,
                      r.restart_sample, r.period_offset, r.period, r.out_channel};
endmodule
